>>> hdl/lati_pkg.sv
package lati_pkg;

	localparam int MAX_STEPS_DEF    = 63;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_ITERS_DEF = 24;

	// CORDIC datapath width: Q16.16 offsets with guard bits plus growth
	localparam int CW      = 42;
	localparam int GUARD   = 4;
	localparam int ZW      = 34;
	localparam int KW      = 5;
	localparam logic [23:0] KGAIN = 24'd10188014;

	// configuration register indexes
	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_START_Z = 2'd2;

	// shared divider: dividend up to |sweep| * 2^32, divisor up to 360 * 2^FRAC * n
	localparam int DVD_W = 58;
	localparam int DVS_W = 40;
	localparam int DCW   = 6;

	typedef enum logic [2:0] {
		DIV_LX, DIV_LY, DIV_LZ, DIV_SA, DIV_SE
	} div_sel_t;

	typedef enum logic [1:0] {
		COR_V1, COR_V2, COR_R1, COR_R2
	} cor_src_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_LINE_OUT, ST_ARC_CHK,
		ST_V1, ST_V1_WAIT, ST_K1A, ST_K1B, ST_V2, ST_V2_WAIT,
		ST_K2A, ST_K2B, ST_K3A, ST_K3B, ST_KR,
		ST_R1, ST_R1_WAIT, ST_K4A, ST_K4B, ST_R2, ST_R2_WAIT, ST_ARC_OUT
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     div_go;
		logic     div_store;
		div_sel_t div_sel;
		logic     cor_go;
		cor_src_t cor_src;
		logic     az_load;
		logic     el_load;
		logic     ks_ph1;
		logic     ks_ph2;
		logic     ks_from_q;
		logic     kr_load;
		logic     ey_load;
		logic     line_out;
		logic     arc_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cor_done;
		logic zero_rad;
		logic last;
		logic out_free;
	} stat_t;

	// arctan(2^-k) in binary angle (2^32 = one turn)
	function automatic logic [31:0] atan_turns(input logic [KW-1:0] k);
		logic [31:0] r;
		case (k)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [CW:0] v);
		logic [31:0] r;
		if (v > $signed({{(CW-31){1'b0}}, {31{1'b1}}}))
			r = 32'h7FFF_FFFF;
		else if (v < $signed({{(CW-31){1'b1}}, {31{1'b0}}}))
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> hdl/lati_div.sv
// unsigned restoring divider, one quotient bit per cycle
module lati_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [lati_pkg::DVD_W-1:0]    dividend,
	input  logic [lati_pkg::DVS_W-1:0]    divisor,
	output logic                          done,
	output logic [lati_pkg::DVD_W-1:0]    quotient
);
	localparam int DVD_W = lati_pkg::DVD_W;
	localparam int DVS_W = lati_pkg::DVS_W;
	localparam int DCW   = lati_pkg::DCW;

	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DCW-1:0]   cnt_q;
	logic             run_q, done_q;
	logic [DVS_W:0]   shifted, trial;
	logic             fits;

	always_comb begin
		shifted = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
		fits    = shifted >= {1'b0, dvs_q};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCW'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? trial : shifted;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

>>> hdl/lati_cordic.sv
// iterative CORDIC, vectoring or rotation, one micro-rotation per cycle
module lati_cordic #(
	parameter int ITERS = lati_pkg::CORDIC_ITERS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic                              vec,
	input  logic signed [lati_pkg::CW-1:0]    x_in,
	input  logic signed [lati_pkg::CW-1:0]    y_in,
	input  logic [31:0]                       ang_in,
	output logic                              done,
	output logic signed [lati_pkg::CW-1:0]    x_out,
	output logic signed [lati_pkg::CW-1:0]    y_out,
	output logic [31:0]                       ang_out
);
	localparam int CW = lati_pkg::CW;
	localparam int ZW = lati_pkg::ZW;
	localparam int KW = lati_pkg::KW;

	logic signed [CW-1:0] x_q, y_q, xs, ys, nx, ny;
	logic signed [ZW-1:0] z_q;
	logic [31:0]          a_q, at, ang_sh, ang_f;
	logic [KW-1:0]        k_q;
	logic                 vec_q, flip_q, run_q, done_q, cw, flip_in;

	always_comb begin
		xs = x_q >>> k_q;
		ys = y_q >>> k_q;
		at = lati_pkg::atan_turns(k_q);
		cw = vec_q ? (y_q > 0) : z_q[ZW-1];
		nx = cw ? x_q + ys : x_q - ys;
		ny = cw ? y_q - xs : y_q + xs;
		ang_sh  = ang_in + 32'h4000_0000;
		flip_in = ang_sh[31];
		ang_f   = flip_in ? (ang_in ^ 32'h8000_0000) : ang_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == KW'(ITERS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			vec_q <= vec;
			if (vec) begin
				flip_q <= 1'b0;
				z_q    <= '0;
				if (x_in < 0) begin
					x_q <= -x_in;
					y_q <= -y_in;
					a_q <= 32'h8000_0000;
				end else begin
					x_q <= x_in;
					y_q <= y_in;
					a_q <= '0;
				end
			end else begin
				flip_q <= flip_in;
				z_q    <= ZW'($signed(ang_f));
				x_q    <= x_in;
				y_q    <= y_in;
				a_q    <= '0;
			end
		end else if (run_q) begin
			a_q <= cw ? a_q + at : a_q - at;
			z_q <= cw ? z_q + $signed({2'b00, at}) : z_q - $signed({2'b00, at});
			if (k_q == KW'(ITERS - 1) && flip_q) begin
				x_q <= -nx;
				y_q <= -ny;
			end else begin
				x_q <= nx;
				y_q <= ny;
			end
		end
	end

	assign done    = done_q;
	assign x_out   = x_q;
	assign y_out   = y_q;
	assign ang_out = a_q;
endmodule

>>> hdl/lati_datapath.sv
// command registers, step and angle accumulators, gain scaling, output word
module lati_datapath #(
	parameter int MAX_STEPS    = lati_pkg::MAX_STEPS_DEF,
	parameter int FRAC_BITS    = lati_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_ITERS = lati_pkg::CORDIC_ITERS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lati_pkg::cmd_t        cmd,
	output lati_pkg::stat_t       stat,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_sel,
	input  logic [31:0]           cfg_wdata,
	input  logic [31:0]           in_x,
	input  logic [31:0]           in_y,
	input  logic [31:0]           in_z,
	input  logic [25:0]           in_az,
	input  logic [25:0]           in_el,
	input  logic [5:0]            in_n,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [95:0]           out_xyz,
	output logic                  out_last
);
	localparam int CW    = lati_pkg::CW;
	localparam int DVD_W = lati_pkg::DVD_W;
	localparam int DVS_W = lati_pkg::DVS_W;
	localparam logic [DVS_W-1:0] DEN_BASE = DVS_W'(360) << FRAC_BITS;

	logic [31:0] start_x_q, start_y_q, start_z_q, prev_x_q, prev_y_q, prev_z_q;
	logic        have_q;
	logic signed [31:0] rx_q, ry_q, rz_q, px_q, py_q, pz_q;
	logic signed [25:0] az_sw_q, el_sw_q;
	logic [5:0]  n_q, i_q;
	logic signed [34:0] stp_x_q, stp_y_q, stp_z_q;
	logic signed [35:0] acc_x_q, acc_y_q, acc_z_q;
	logic [31:0] sa_q, se_q, az_q, el_q;
	logic signed [CW-1:0] ks_q, kr_q, ey_q;
	logic [44:0] ks_lo_s1;
	logic signed [20:0] ks_hi_s1;
	logic        ov_q;
	logic [95:0] oxyz_q;
	logic        olast_q;

	// divider
	logic [DVD_W-1:0] dvd, quo;
	logic [DVS_W-1:0] dvs;
	logic             dneg, ddone;
	logic signed [32:0] diff;
	logic signed [25:0] sw;
	logic [DVD_W-1:0]   q_s;

	always_comb begin
		diff = 33'sd0;
		sw   = 26'sd0;
		case (cmd.div_sel)
			lati_pkg::DIV_LX: diff = 33'(px_q) - 33'(rx_q);
			lati_pkg::DIV_LY: diff = 33'(py_q) - 33'(ry_q);
			lati_pkg::DIV_LZ: diff = 33'(pz_q) - 33'(rz_q);
			lati_pkg::DIV_SA: sw = az_sw_q;
			default:          sw = el_sw_q;
		endcase
		if (cmd.div_sel == lati_pkg::DIV_SA || cmd.div_sel == lati_pkg::DIV_SE) begin
			dvd  = {(sw[25] ? 26'(-sw) : 26'(sw)), 32'b0};
			dvs  = DVS_W'(DEN_BASE * DVS_W'(n_q));
		end else begin
			dvd  = DVD_W'(diff[32] ? 33'(-diff) : 33'(diff));
			dvs  = DVS_W'(n_q);
		end
	end

	// sign is latched with the request so the store sees the same one
	always_ff @(posedge clk) begin
		if (cmd.div_go)
			dneg <= (cmd.div_sel == lati_pkg::DIV_SA || cmd.div_sel == lati_pkg::DIV_SE)
				? sw[25] : diff[32];
	end

	assign q_s = dneg ? -quo : quo;

	lati_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go), .dividend(dvd), .divisor(dvs),
		.done(ddone), .quotient(quo)
	);

	// CORDIC
	logic signed [CW-1:0] cx_in, cy_in, cx, cy;
	logic [31:0]          cang_in, cang;
	logic                 cvec, cdone;
	logic signed [36:0]   dx, dy, dz;

	always_comb begin
		dx = 37'(33'(rx_q) - 33'(px_q)) <<< lati_pkg::GUARD;
		dy = 37'(33'(ry_q) - 33'(py_q)) <<< lati_pkg::GUARD;
		dz = 37'(33'(rz_q) - 33'(pz_q)) <<< lati_pkg::GUARD;
		cvec    = 1'b0;
		cang_in = az_q;
		cy_in   = '0;
		cx_in   = ks_q;
		case (cmd.cor_src)
			lati_pkg::COR_V1: begin
				cvec = 1'b1; cx_in = CW'(dx); cy_in = CW'(dy);
			end
			lati_pkg::COR_V2: begin
				cvec = 1'b1; cx_in = ks_q; cy_in = CW'(dz);
			end
			lati_pkg::COR_R1: begin
				cx_in = kr_q; cang_in = el_q;
			end
			default: begin
				cx_in = ks_q; cang_in = az_q;
			end
		endcase
	end

	lati_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .go(cmd.cor_go), .vec(cvec),
		.x_in(cx_in), .y_in(cy_in), .ang_in(cang_in),
		.done(cdone), .x_out(cx), .y_out(cy), .ang_out(cang)
	);

	// gain compensation, split into two 21 x 24 partial products
	logic signed [CW-1:0] ks_src;
	logic signed [45:0]   ks_hp;
	logic signed [66:0]   ks_sum;

	always_comb begin
		ks_src = cmd.ks_from_q ? ks_q : cx;
		ks_hp  = ks_hi_s1 * $signed({1'b0, lati_pkg::KGAIN});
		ks_sum = (67'(ks_hp) <<< 21) + $signed({22'b0, ks_lo_s1}) + 67'sd8388608;
	end

	// output values
	logic signed [CW:0] ax, ay, az, lx, ly, lz;
	logic signed [CW-1:0] ugx, ugy, ugz;
	always_comb begin
		ugx = (cx   + CW'(8)) >>> lati_pkg::GUARD;
		ugy = (cy   + CW'(8)) >>> lati_pkg::GUARD;
		ugz = (ey_q + CW'(8)) >>> lati_pkg::GUARD;
		ax  = (CW+1)'(px_q) + (CW+1)'(ugx);
		ay  = (CW+1)'(py_q) + (CW+1)'(ugy);
		az  = (CW+1)'(pz_q) + (CW+1)'(ugz);
		lx  = (CW+1)'(acc_x_q);
		ly  = (CW+1)'(acc_y_q);
		lz  = (CW+1)'(acc_z_q);
	end

	logic [31:0] ox, oy, oz;
	always_comb begin
		if (cmd.arc_out) begin
			ox = lati_pkg::sat32(ax);
			oy = lati_pkg::sat32(ay);
			oz = lati_pkg::sat32(az);
		end else begin
			ox = lati_pkg::sat32(lx);
			oy = lati_pkg::sat32(ly);
			oz = lati_pkg::sat32(lz);
		end
	end

	logic out_load;
	assign out_load = cmd.line_out | cmd.arc_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_z_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			prev_z_q  <= '0;
			have_q    <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_sel)
					lati_pkg::REG_START_X: start_x_q <= cfg_wdata;
					lati_pkg::REG_START_Y: start_y_q <= cfg_wdata;
					lati_pkg::REG_START_Z: start_z_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_load) begin
				prev_x_q <= ox;
				prev_y_q <= oy;
				prev_z_q <= oz;
				have_q   <= 1'b1;
				ov_q     <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rx_q    <= have_q ? prev_x_q : start_x_q;
			ry_q    <= have_q ? prev_y_q : start_y_q;
			rz_q    <= have_q ? prev_z_q : start_z_q;
			acc_x_q <= 36'($signed(have_q ? prev_x_q : start_x_q));
			acc_y_q <= 36'($signed(have_q ? prev_y_q : start_y_q));
			acc_z_q <= 36'($signed(have_q ? prev_z_q : start_z_q));
			px_q    <= in_x;
			py_q    <= in_y;
			pz_q    <= in_z;
			az_sw_q <= in_az;
			el_sw_q <= in_el;
			n_q     <= (in_n > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : in_n;
			i_q     <= '0;
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				lati_pkg::DIV_LX: stp_x_q <= 35'(q_s);
				lati_pkg::DIV_LY: stp_y_q <= 35'(q_s);
				lati_pkg::DIV_LZ: stp_z_q <= 35'(q_s);
				lati_pkg::DIV_SA: sa_q    <= q_s[31:0];
				default:          se_q    <= q_s[31:0];
			endcase
		end
		if (cmd.az_load) az_q <= cang;
		if (cmd.el_load) el_q <= cang;
		if (cmd.ks_ph1) begin
			ks_lo_s1 <= 45'(ks_src[20:0]) * 45'(lati_pkg::KGAIN);
			ks_hi_s1 <= ks_src[CW-1:21];
		end
		if (cmd.ks_ph2)  ks_q <= CW'(ks_sum >>> 24);
		if (cmd.kr_load) kr_q <= ks_q;
		if (cmd.ey_load) ey_q <= cy;
		if (cmd.line_out) begin
			acc_x_q <= acc_x_q + 36'(stp_x_q);
			acc_y_q <= acc_y_q + 36'(stp_y_q);
			acc_z_q <= acc_z_q + 36'(stp_z_q);
			i_q     <= i_q + 1'b1;
		end
		if (cmd.arc_out) begin
			az_q <= az_q + sa_q;
			el_q <= el_q + se_q;
			i_q  <= i_q + 1'b1;
		end
		if (out_load) begin
			oxyz_q  <= {oz, oy, ox};
			olast_q <= (i_q == n_q);
		end
	end

	assign stat.div_done = ddone;
	assign stat.cor_done = cdone;
	assign stat.zero_rad = (rx_q == px_q) && (ry_q == py_q) && (rz_q == pz_q);
	assign stat.last     = (i_q == n_q);
	assign stat.out_free = !ov_q || out_ready;

	assign out_valid = ov_q;
	assign out_xyz   = oxyz_q;
	assign out_last  = olast_q;
endmodule

>>> hdl/lati_ctrl.sv
// command sequencer
module lati_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_arc,
	input  logic              in_empty,
	output logic              in_ready,
	input  lati_pkg::stat_t   stat,
	output lati_pkg::cmd_t    cmd
);
	lati_pkg::state_t   state_q, state_d;
	lati_pkg::div_sel_t sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lati_pkg::ST_IDLE;
			sel_q   <= lati_pkg::DIV_LX;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		cmd.cor_src = lati_pkg::COR_V1;
		in_ready    = 1'b0;
		unique case (state_q)
			lati_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && !in_empty) begin
					sel_d   = lati_pkg::DIV_LX;
					state_d = in_arc ? lati_pkg::ST_ARC_CHK : lati_pkg::ST_DIV_GO;
				end
			end
			lati_pkg::ST_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_d    = lati_pkg::ST_DIV_WAIT;
			end
			lati_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = lati_pkg::ST_DIV_GO;
					unique case (sel_q)
						lati_pkg::DIV_LX: sel_d = lati_pkg::DIV_LY;
						lati_pkg::DIV_LY: sel_d = lati_pkg::DIV_LZ;
						lati_pkg::DIV_LZ: state_d = lati_pkg::ST_LINE_OUT;
						lati_pkg::DIV_SA: sel_d = lati_pkg::DIV_SE;
						default:          state_d = lati_pkg::ST_R1;
					endcase
				end
			end
			lati_pkg::ST_LINE_OUT: begin
				if (stat.out_free) begin
					cmd.line_out = 1'b1;
					if (stat.last) state_d = lati_pkg::ST_IDLE;
				end
			end
			lati_pkg::ST_ARC_CHK:
				state_d = stat.zero_rad ? lati_pkg::ST_IDLE : lati_pkg::ST_V1;
			lati_pkg::ST_V1: begin
				cmd.cor_go  = 1'b1;
				cmd.cor_src = lati_pkg::COR_V1;
				state_d     = lati_pkg::ST_V1_WAIT;
			end
			lati_pkg::ST_V1_WAIT: begin
				if (stat.cor_done) begin
					cmd.az_load = 1'b1;
					state_d     = lati_pkg::ST_K1A;
				end
			end
			lati_pkg::ST_K1A: begin
				cmd.ks_ph1 = 1'b1;
				state_d    = lati_pkg::ST_K1B;
			end
			lati_pkg::ST_K1B: begin
				cmd.ks_ph2 = 1'b1;
				state_d    = lati_pkg::ST_V2;
			end
			lati_pkg::ST_V2: begin
				cmd.cor_go  = 1'b1;
				cmd.cor_src = lati_pkg::COR_V2;
				state_d     = lati_pkg::ST_V2_WAIT;
			end
			lati_pkg::ST_V2_WAIT: begin
				if (stat.cor_done) begin
					cmd.el_load = 1'b1;
					state_d     = lati_pkg::ST_K2A;
				end
			end
			lati_pkg::ST_K2A: begin
				cmd.ks_ph1 = 1'b1;
				state_d    = lati_pkg::ST_K2B;
			end
			lati_pkg::ST_K2B: begin
				cmd.ks_ph2 = 1'b1;
				state_d    = lati_pkg::ST_K3A;
			end
			lati_pkg::ST_K3A: begin
				cmd.ks_ph1    = 1'b1;
				cmd.ks_from_q = 1'b1;
				state_d       = lati_pkg::ST_K3B;
			end
			lati_pkg::ST_K3B: begin
				cmd.ks_ph2 = 1'b1;
				state_d    = lati_pkg::ST_KR;
			end
			lati_pkg::ST_KR: begin
				cmd.kr_load = 1'b1;
				sel_d       = lati_pkg::DIV_SA;
				state_d     = lati_pkg::ST_DIV_GO;
			end
			lati_pkg::ST_R1: begin
				cmd.cor_go  = 1'b1;
				cmd.cor_src = lati_pkg::COR_R1;
				state_d     = lati_pkg::ST_R1_WAIT;
			end
			lati_pkg::ST_R1_WAIT: begin
				if (stat.cor_done) begin
					cmd.ey_load = 1'b1;
					state_d     = lati_pkg::ST_K4A;
				end
			end
			lati_pkg::ST_K4A: begin
				cmd.ks_ph1 = 1'b1;
				state_d    = lati_pkg::ST_K4B;
			end
			lati_pkg::ST_K4B: begin
				cmd.ks_ph2 = 1'b1;
				state_d    = lati_pkg::ST_R2;
			end
			lati_pkg::ST_R2: begin
				cmd.cor_go  = 1'b1;
				cmd.cor_src = lati_pkg::COR_R2;
				state_d     = lati_pkg::ST_R2_WAIT;
			end
			lati_pkg::ST_R2_WAIT: begin
				if (stat.cor_done) state_d = lati_pkg::ST_ARC_OUT;
			end
			lati_pkg::ST_ARC_OUT: begin
				if (stat.out_free) begin
					cmd.arc_out = 1'b1;
					state_d     = stat.last ? lati_pkg::ST_IDLE : lati_pkg::ST_R1;
				end
			end
			default: state_d = lati_pkg::ST_IDLE;
		endcase
	end
endmodule

>>> hdl/line_arc_trajectory_interpolator_core.sv
// Line / spherical-arc path interpolator. Each input word is one path command;
// it yields n+1 output words (n = step_count, clamped to MAX_STEPS), the first
// being the reference point (last point sent, or start_x/y/z before any).
// step_count of zero, or an arc whose reference sits on the centre, yields
// nothing. Points are Q16.16 and saturated; tlast marks the final point.
// Timing: a line first runs three divisions for its steps, then gives one point
// per cycle while the output is free. An arc costs two vectoring CORDIC runs
// plus two sweep divisions, then two rotation CORDIC runs and a gain scaling
// per point; the shared 58-bit restoring divider and the single iterative
// CORDIC take one request at a time.
// s_axis_tready is high only between commands; the output register lets the
// next command start while the last point still waits. Config writes are
// always taken (cfg_ready tied high) and must only happen while idle.
module line_arc_trajectory_interpolator_core #(
	parameter int MAX_STEPS    = lati_pkg::MAX_STEPS_DEF,
	parameter int FRAC_BITS    = lati_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_ITERS = lati_pkg::CORDIC_ITERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// config write: index 0 start_x, 1 start_y, 2 start_z
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// command word
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_x[31:0], point_y[63:32], point_z[95:64], azimuth_sweep[121:96],
	// elevation_sweep[147:122], step_count[153:148], zero fill [159:154]
	input  logic [159:0] s_axis_tdata,
	// cmd: 0 line, 1 arc
	input  logic         s_axis_tuser,
	// point word
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [95:0]  m_axis_tdata,
	output logic         m_axis_tlast
);
	lati_pkg::cmd_t  cmd;
	lati_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	lati_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_arc(s_axis_tuser),
		.in_empty(s_axis_tdata[153:148] == 6'd0),
		.in_ready(s_axis_tready), .stat(stat), .cmd(cmd)
	);

	lati_datapath #(
		.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS), .CORDIC_ITERS(CORDIC_ITERS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_valid), .cfg_sel(cfg_index), .cfg_wdata(cfg_data),
		.in_x(s_axis_tdata[31:0]), .in_y(s_axis_tdata[63:32]),
		.in_z(s_axis_tdata[95:64]), .in_az(s_axis_tdata[121:96]),
		.in_el(s_axis_tdata[147:122]), .in_n(s_axis_tdata[153:148]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_xyz(m_axis_tdata), .out_last(m_axis_tlast)
	);
endmodule
